>>> rtl/core/redr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// redr_pkg
// shared constants and register map of the resource element demapper
// ----------------------------------------------------------------------------
package redr_pkg;

  localparam int SLOTS_PER_SYMBOL = 4096;
  localparam int SC_PER_RB        = 12;

  localparam int PORT_W  = 3;
  localparam int SYM_W   = 4;
  localparam int SC_W    = 12;
  localparam int WORD_W  = 32;
  localparam int ADDR_W  = 13;
  localparam int RB_W    = 9;
  localparam int MASK_W  = 14;
  localparam int CNT_W   = 4;

  localparam int RB_SUM_W = RB_W + 2;
  localparam int SC_EXT_W = 15;

  localparam int IN_DATA_W  = 88;
  localparam int OUT_DATA_W = 104;

  localparam int APB_ADDR_W = 5;
  localparam int APB_DATA_W = 32;

  typedef enum logic [2:0] {
    REG_BWP_START_RB    = 3'd0,
    REG_ALLOC_START_RB  = 3'd1,
    REG_ALLOC_RB_COUNT  = 3'd2,
    REG_FIRST_SYMBOL    = 3'd3,
    REG_SYMBOL_COUNT    = 3'd4,
    REG_DMRS_SYMBOL_MASK = 3'd5,
    REG_PORT_COUNT      = 3'd6,
    REG_UNUSED          = 3'd7
  } reg_idx_t;

endpackage

>>> rtl/core/resource_element_demap_reorder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// resource_element_demap_reorder
// maps received resource elements of an allocation to planar buffer slots,
// splitting even and odd subcarriers on dmrs symbols
// one request per cycle, unless all stages are full and out_tready is low
// three register stages: range checks, subcarrier offset, slot addresses
// dropped elements leave the pipeline at the last stage without a result
// synchronous active-low reset clears stage valids and sets config defaults
// ----------------------------------------------------------------------------
module resource_element_demap_reorder
  import redr_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  // port, symbol, subcarrier, real_word, imag_word
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_DATA_W-1:0]   in_tdata,
  // out_port, out_symbol, real_addr, imag_addr, real_out, imag_out
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_DATA_W-1:0]  out_tdata,
  // is_dmrs
  output logic [0:0]             out_tuser,
  input  logic                   cfg_psel,
  input  logic                   cfg_penable,
  input  logic                   cfg_pwrite,
  input  logic [APB_ADDR_W-1:0]  cfg_paddr,
  input  logic [APB_DATA_W-1:0]  cfg_pwdata,
  output logic [APB_DATA_W-1:0]  cfg_prdata,
  output logic                   cfg_pready
);

  localparam logic [ADDR_W-1:0]   N_SLOTS  = ADDR_W'(SLOTS_PER_SYMBOL);
  localparam logic [ADDR_W-1:0]   N_HALF   = ADDR_W'(SLOTS_PER_SYMBOL / 2);
  localparam logic [SC_EXT_W-1:0] N_LIMIT  = SC_EXT_W'(SLOTS_PER_SYMBOL);

  // configuration registers
  logic [RB_W-1:0]   bwp_start_rb_r;
  logic [RB_W-1:0]   alloc_start_rb_r;
  logic [RB_W-1:0]   alloc_rb_count_r;
  logic [CNT_W-1:0]  first_symbol_r;
  logic [CNT_W-1:0]  symbol_count_r;
  logic [MASK_W-1:0] dmrs_symbol_mask_r;
  logic [CNT_W-1:0]  port_count_r;

  reg_idx_t cfg_idx;
  logic     cfg_wr;

  assign cfg_idx    = reg_idx_t'(cfg_paddr[APB_ADDR_W-1:2]);
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;
  assign cfg_pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bwp_start_rb_r     <= '0;
      alloc_start_rb_r   <= '0;
      alloc_rb_count_r   <= RB_W'(1);
      first_symbol_r     <= '0;
      symbol_count_r     <= CNT_W'(14);
      dmrs_symbol_mask_r <= '0;
      port_count_r       <= CNT_W'(1);
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_BWP_START_RB:     bwp_start_rb_r     <= cfg_pwdata[RB_W-1:0];
        REG_ALLOC_START_RB:   alloc_start_rb_r   <= cfg_pwdata[RB_W-1:0];
        REG_ALLOC_RB_COUNT:   alloc_rb_count_r   <= cfg_pwdata[RB_W-1:0];
        REG_FIRST_SYMBOL:     first_symbol_r     <= cfg_pwdata[CNT_W-1:0];
        REG_SYMBOL_COUNT:     symbol_count_r     <= cfg_pwdata[CNT_W-1:0];
        REG_DMRS_SYMBOL_MASK: dmrs_symbol_mask_r <= cfg_pwdata[MASK_W-1:0];
        REG_PORT_COUNT:       port_count_r       <= cfg_pwdata[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_BWP_START_RB:     cfg_prdata = APB_DATA_W'(bwp_start_rb_r);
      REG_ALLOC_START_RB:   cfg_prdata = APB_DATA_W'(alloc_start_rb_r);
      REG_ALLOC_RB_COUNT:   cfg_prdata = APB_DATA_W'(alloc_rb_count_r);
      REG_FIRST_SYMBOL:     cfg_prdata = APB_DATA_W'(first_symbol_r);
      REG_SYMBOL_COUNT:     cfg_prdata = APB_DATA_W'(symbol_count_r);
      REG_DMRS_SYMBOL_MASK: cfg_prdata = APB_DATA_W'(dmrs_symbol_mask_r);
      REG_PORT_COUNT:       cfg_prdata = APB_DATA_W'(port_count_r);
      default:              cfg_prdata = '0;
    endcase
  end

  // input unpacking
  logic [PORT_W-1:0] in_port;
  logic [SYM_W-1:0]  in_symbol;
  logic [SC_W-1:0]   in_subcarrier;
  logic [WORD_W-1:0] in_real;
  logic [WORD_W-1:0] in_imag;

  assign in_port       = in_tdata[2:0];
  assign in_symbol     = in_tdata[6:3];
  assign in_subcarrier = in_tdata[18:7];
  assign in_real       = in_tdata[50:19];
  assign in_imag       = in_tdata[82:51];

  // pipeline flow control
  logic s1_v_r, s2_v_r, s3_v_r;
  logic s1_adv, s2_adv, s3_adv;
  logic s1_rdy, s2_rdy, s3_rdy;

  assign s3_rdy    = !s3_v_r || out_tready;
  assign s2_rdy    = !s2_v_r || s3_rdy;
  assign s1_rdy    = !s1_v_r || s2_rdy;
  assign in_tready = s1_rdy;
  assign s1_adv    = s1_rdy;
  assign s2_adv    = s2_rdy;
  assign s3_adv    = s3_rdy;

  // stage 1: port and symbol checks, rb sums
  logic [PORT_W-1:0]   s1_port_r;
  logic [SYM_W-1:0]    s1_sym_rel_r;
  logic [SC_W-1:0]     s1_sc_r;
  logic [WORD_W-1:0]   s1_real_r;
  logic [WORD_W-1:0]   s1_imag_r;
  logic                s1_dmrs_r;
  logic                s1_keep_r;
  logic [RB_SUM_W-1:0] s1_rb_lo_r;
  logic [RB_SUM_W-1:0] s1_rb_hi_r;

  logic [SYM_W:0]      sym_end;
  logic [15:0]         mask_ext;
  logic                port_ok, sym_ok;
  logic [RB_SUM_W-1:0] rb_lo_nxt;

  assign sym_end   = {1'b0, first_symbol_r} + {1'b0, symbol_count_r};
  assign mask_ext  = {2'b00, dmrs_symbol_mask_r};
  assign port_ok   = {1'b0, in_port} < port_count_r;
  assign sym_ok    = (in_symbol >= first_symbol_r) && ({1'b0, in_symbol} < sym_end);
  assign rb_lo_nxt = RB_SUM_W'(bwp_start_rb_r) + RB_SUM_W'(alloc_start_rb_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (s1_adv) begin
      s1_v_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && in_tvalid) begin
      s1_port_r    <= in_port;
      s1_sym_rel_r <= in_symbol - first_symbol_r;
      s1_sc_r      <= in_subcarrier;
      s1_real_r    <= in_real;
      s1_imag_r    <= in_imag;
      s1_dmrs_r    <= mask_ext[in_symbol];
      s1_keep_r    <= port_ok && sym_ok;
      s1_rb_lo_r   <= rb_lo_nxt;
      s1_rb_hi_r   <= rb_lo_nxt + RB_SUM_W'(alloc_rb_count_r);
    end
  end

  // stage 2: subcarrier window and offset
  logic [PORT_W-1:0] s2_port_r;
  logic [SYM_W-1:0]  s2_sym_rel_r;
  logic [WORD_W-1:0] s2_real_r;
  logic [WORD_W-1:0] s2_imag_r;
  logic              s2_dmrs_r;
  logic              s2_keep_r;
  logic [ADDR_W-1:0] s2_k_r;

  logic [SC_EXT_W-1:0] sc_lo, sc_hi, sc_ext, k_full;
  logic                sc_ok;

  assign sc_lo  = (SC_EXT_W'(s1_rb_lo_r) << 3) + (SC_EXT_W'(s1_rb_lo_r) << 2);
  assign sc_hi  = (SC_EXT_W'(s1_rb_hi_r) << 3) + (SC_EXT_W'(s1_rb_hi_r) << 2);
  assign sc_ext = SC_EXT_W'(s1_sc_r);
  assign k_full = sc_ext - sc_lo;
  assign sc_ok  = (sc_ext >= sc_lo) && (sc_ext < sc_hi) && (k_full < N_LIMIT);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else if (s2_adv) begin
      s2_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_adv && s1_v_r) begin
      s2_port_r    <= s1_port_r;
      s2_sym_rel_r <= s1_sym_rel_r;
      s2_real_r    <= s1_real_r;
      s2_imag_r    <= s1_imag_r;
      s2_dmrs_r    <= s1_dmrs_r;
      s2_keep_r    <= s1_keep_r && sc_ok;
      s2_k_r       <= k_full[ADDR_W-1:0];
    end
  end

  // stage 3: slot addresses, output register
  logic [PORT_W-1:0] s3_port_r;
  logic [SYM_W-1:0]  s3_sym_rel_r;
  logic [ADDR_W-1:0] s3_ra_r;
  logic [ADDR_W-1:0] s3_ia_r;
  logic [WORD_W-1:0] s3_real_r;
  logic [WORD_W-1:0] s3_imag_r;
  logic              s3_dmrs_r;

  logic [ADDR_W-1:0] ra_nxt, ia_nxt, ra_dmrs;

  assign ra_dmrs = (s2_k_r[0] ? N_SLOTS : '0) + (s2_k_r >> 1);
  assign ra_nxt  = s2_dmrs_r ? ra_dmrs : s2_k_r;
  assign ia_nxt  = s2_dmrs_r ? ra_dmrs + N_HALF : N_SLOTS + s2_k_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_v_r <= 1'b0;
    end else if (s3_adv) begin
      s3_v_r <= s2_v_r && s2_keep_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s3_adv && s2_v_r && s2_keep_r) begin
      s3_port_r    <= s2_port_r;
      s3_sym_rel_r <= s2_sym_rel_r;
      s3_ra_r      <= ra_nxt;
      s3_ia_r      <= ia_nxt;
      s3_real_r    <= s2_real_r;
      s3_imag_r    <= s2_imag_r;
      s3_dmrs_r    <= s2_dmrs_r;
    end
  end

  assign out_tvalid = s3_v_r;
  assign out_tdata  = {7'b0, s3_imag_r, s3_real_r, s3_ia_r, s3_ra_r,
                       s3_sym_rel_r, s3_port_r};
  assign out_tuser  = s3_dmrs_r;

  // checks
  a_data_imag_offset: assert property (@(posedge clk) disable iff (!rst_n)
    (s3_v_r && !s3_dmrs_r) |-> (s3_ia_r == s3_ra_r + N_SLOTS))
    else $error("data symbol imag slot not one plane past real slot");

  a_dmrs_imag_offset: assert property (@(posedge clk) disable iff (!rst_n)
    (s3_v_r && s3_dmrs_r) |-> (s3_ia_r == s3_ra_r + N_HALF))
    else $error("dmrs imag slot not half a plane past real slot");

  a_data_real_plane: assert property (@(posedge clk) disable iff (!rst_n)
    (s3_v_r && !s3_dmrs_r) |-> (s3_ra_r < N_SLOTS))
    else $error("data symbol real slot outside first plane");

  a_stall_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> (s1_v_r && s2_v_r && s3_v_r && !out_tready))
    else $error("input stalled with room in pipeline");

  a_drop_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    (s3_adv && s2_v_r && !s2_keep_r) |=> !s3_v_r)
    else $error("dropped element produced a result");

endmodule

>>> tb/sv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the resource element demapper. Resource elements are
// pushed into the input stream while a local slot calculator predicts, from
// the register settings, whether each element falls inside the allocation and
// which planar buffer slots it maps to. Every result request is compared field
// by field with the oldest prediction. A directed table covers the reset state,
// range edges, dmrs splitting, symbols past the mask and the empty
// allocations. Random phases then sweep many register settings under varying
// backpressure, with one long receiver hold-off and one drain within a phase.
// ----------------------------------------------------------------------------
module testbench;
  import redr_pkg::*;

  typedef struct packed {
    logic [WORD_W-1:0] im;
    logic [WORD_W-1:0] re;
    logic [SC_W-1:0]   sc;
    logic [SYM_W-1:0]  sym;
    logic [PORT_W-1:0] port;
  } re_elem_t;

  typedef struct packed {
    logic              dmrs;
    logic [WORD_W-1:0] im;
    logic [WORD_W-1:0] re;
    logic [ADDR_W-1:0] ia;
    logic [ADDR_W-1:0] ra;
    logic [SYM_W-1:0]  sym;
    logic [PORT_W-1:0] port;
  } re_slot_t;

  typedef struct packed {
    bit                wr;
    reg_idx_t          idx;
    logic [31:0]       val;
    logic [PORT_W-1:0] port;
    logic [SYM_W-1:0]  sym;
    logic [SC_W-1:0]   sc;
    logic [WORD_W-1:0] re;
    logic [WORD_W-1:0] im;
    bit                typed;
    bit                hit;
    logic [SYM_W-1:0]  o_sym;
    logic [ADDR_W-1:0] ra;
    logic [ADDR_W-1:0] ia;
    bit                dmrs;
  } dir_row_t;

  localparam int DIR_N     = 36;
  localparam int HOLD_AT   = 400;
  localparam int HOLD_LEN  = 500;
  localparam int PHASES    = 8;
  localparam int PHASE_HIT = 150;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic [0:0]            out_tuser;
  logic                  cfg_psel = 1'b0;
  logic                  cfg_penable = 1'b0;
  logic                  cfg_pwrite = 1'b0;
  logic [APB_ADDR_W-1:0] cfg_paddr = '0;
  logic [APB_DATA_W-1:0] cfg_pwdata = '0;
  logic [APB_DATA_W-1:0] cfg_prdata;
  logic                  cfg_pready;

  // register shadow
  logic [RB_W-1:0]   c_bwp = '0;
  logic [RB_W-1:0]   c_alloc = '0;
  logic [RB_W-1:0]   c_cnt = 9'd1;
  logic [CNT_W-1:0]  c_first = '0;
  logic [CNT_W-1:0]  c_symcnt = 4'd14;
  logic [MASK_W-1:0] c_mask = '0;
  logic [CNT_W-1:0]  c_ports = 4'd1;

  re_slot_t slot_q [$];
  int       mismatch_cnt = 0;
  int       src_idle_pct = 0;
  int       snk_idle_pct = 0;
  int       in_acc_cnt = 0;
  int       hold_cnt = 0;
  bit       hold_done = 1'b0;
  bit       in_fire = 1'b0;
  bit       cfg_fire = 1'b0;
  bit       pin_typed = 1'b0;
  bit       pin_hit = 1'b0;
  re_slot_t pin_slot = '0;

  resource_element_demap_reorder u_top (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  initial begin
    #2_000_000;
    $display("Verification failed");
    $finish;
  end

  function automatic bit demap_slot(input re_elem_t e, output re_slot_t r);
    int start_sc;
    int end_sc;
    int k;
    int ra;
    bit d;
    r = '0;
    start_sc = (int'(c_bwp) + int'(c_alloc)) * SC_PER_RB;
    end_sc = (int'(c_bwp) + int'(c_alloc) + int'(c_cnt)) * SC_PER_RB;
    if (int'(e.port) >= int'(c_ports)) return 1'b0;
    if (int'(e.sym) < int'(c_first) || int'(e.sym) >= int'(c_first) + int'(c_symcnt))
      return 1'b0;
    if (int'(e.sc) < start_sc || int'(e.sc) >= end_sc) return 1'b0;
    k = int'(e.sc) - start_sc;
    if (k >= SLOTS_PER_SYMBOL) return 1'b0;
    d = 1'b0;
    if (e.sym < 4'd14) d = c_mask[e.sym];
    ra = d ? (k % 2) * SLOTS_PER_SYMBOL + k / 2 : k;
    r.port = e.port;
    r.sym  = e.sym - c_first;
    r.ra   = ADDR_W'(ra);
    r.ia   = d ? ADDR_W'(ra + SLOTS_PER_SYMBOL / 2) : ADDR_W'(SLOTS_PER_SYMBOL + k);
    r.re   = e.re;
    r.im   = e.im;
    r.dmrs = d;
    return 1'b1;
  endfunction

  task automatic check_field(input string name, input logic [31:0] e, input logic [31:0] a);
    if (e !== a) begin
      mismatch_cnt++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, e, a);
    end
  endtask

  // request sampling, prediction and result checking
  always @(posedge clk) begin
    re_elem_t e;
    re_slot_t r;
    re_slot_t got;
    in_fire  <= rst_n && in_tvalid && in_tready;
    cfg_fire <= rst_n && cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
    if (rst_n && in_tvalid && in_tready) begin
      in_acc_cnt <= in_acc_cnt + 1;
      e = re_elem_t'(in_tdata[$bits(re_elem_t)-1:0]);
      if (pin_typed) begin
        if (pin_hit) slot_q.push_back(pin_slot);
      end else if (demap_slot(e, r)) begin
        slot_q.push_back(r);
      end
    end
    if (rst_n && out_tvalid && out_tready) begin
      got = re_slot_t'({out_tuser, out_tdata[$bits(re_slot_t)-2:0]});
      if (slot_q.size() == 0) begin
        mismatch_cnt++;
        $display("%0t: unexpected result, expected none, actual %0h", $time, got);
      end else begin
        r = slot_q.pop_front();
        check_field("out_port", 32'(r.port), 32'(got.port));
        check_field("out_symbol", 32'(r.sym), 32'(got.sym));
        check_field("real_addr", 32'(r.ra), 32'(got.ra));
        check_field("imag_addr", 32'(r.ia), 32'(got.ia));
        check_field("real_out", r.re, got.re);
        check_field("imag_out", r.im, got.im);
        check_field("is_dmrs", 32'(r.dmrs), 32'(got.dmrs));
      end
    end
  end

  // receiver backpressure
  always @(negedge clk) begin
    if (hold_cnt != 0) begin
      hold_cnt = hold_cnt - 1;
      out_tready <= 1'b0;
    end else if (!hold_done && in_acc_cnt >= HOLD_AT) begin
      hold_done = 1'b1;
      hold_cnt = HOLD_LEN;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99, 0) >= snk_idle_pct);
    end
  end

  task automatic write_reg(input reg_idx_t idx, input logic [31:0] val);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= val;
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(negedge clk); while (!cfg_fire);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    @(negedge clk);
    case (idx)
      REG_BWP_START_RB:     c_bwp = val[RB_W-1:0];
      REG_ALLOC_START_RB:   c_alloc = val[RB_W-1:0];
      REG_ALLOC_RB_COUNT:   c_cnt = val[RB_W-1:0];
      REG_FIRST_SYMBOL:     c_first = val[CNT_W-1:0];
      REG_SYMBOL_COUNT:     c_symcnt = val[CNT_W-1:0];
      REG_DMRS_SYMBOL_MASK: c_mask = val[MASK_W-1:0];
      REG_PORT_COUNT:       c_ports = val[CNT_W-1:0];
      default: ;
    endcase
  endtask

  task automatic drain_results();
    in_tvalid <= 1'b0;
    while (slot_q.size() != 0) @(negedge clk);
  endtask

  // dropped elements may still be in flight after the last result
  task automatic settle_idle();
    drain_results();
    repeat (8) @(negedge clk);
  endtask

  task automatic send_elem(input re_elem_t it, input bit typed, input bit hit,
                           input re_slot_t res);
    while ($urandom_range(99, 0) < src_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {{(IN_DATA_W - $bits(re_elem_t)){1'b0}}, it};
    pin_typed = typed;
    pin_hit   = hit;
    pin_slot  = res;
    do @(negedge clk); while (!in_fire);
  endtask

  dir_row_t dir_tab [DIR_N] = '{
    // reset settings
    '{1'b0, REG_UNUSED, 32'd0, 3'd0, 4'd0, 12'd0, 32'h0, 32'h0,
      1'b1, 1'b1, 4'd0, 13'd0, 13'd4096, 1'b0},
    '{1'b0, REG_UNUSED, 32'd0, 3'd0, 4'd13, 12'd11, 32'hFFFFFFFF, 32'hFFFFFFFF,
      1'b1, 1'b1, 4'd13, 13'd11, 13'd4107, 1'b0},
    '{1'b0, REG_UNUSED, 32'd0, 3'd0, 4'd0, 12'd12, 32'h1, 32'h2,
      1'b1, 1'b0, 4'd0, 13'd0, 13'd0, 1'b0},
    '{1'b0, REG_UNUSED, 32'd0, 3'd1, 4'd0, 12'd0, 32'h3, 32'h4,
      1'b1, 1'b0, 4'd0, 13'd0, 13'd0, 1'b0},
    '{1'b0, REG_UNUSED, 32'd0, 3'd7, 4'd0, 12'd0, 32'h5, 32'h6,
      1'b1, 1'b0, 4'd0, 13'd0, 13'd0, 1'b0},
    '{1'b0, REG_UNUSED, 32'd0, 3'd0, 4'd14, 12'd0, 32'h7, 32'h8,
      1'b1, 1'b0, 4'd0, 13'd0, 13'd0, 1'b0},
    '{1'b0, REG_UNUSED, 32'd0, 3'd0, 4'd15, 12'd0, 32'h9, 32'hA,
      1'b1, 1'b0, 4'd0, 13'd0, 13'd0, 1'b0},
    '{1'b0, REG_UNUSED, 32'd0, 3'd0, 4'd0, 12'd4095, 32'hB, 32'hC,
      1'b1, 1'b0, 4'd0, 13'd0, 13'd0, 1'b0},
    // offset allocation, all symbols dmrs, all ports
    '{1'b1, REG_BWP_START_RB, 32'd10, 3'd0, 4'd0, 12'd0, 32'h0, 32'h0,
      1'b0, 1'b0, 4'd0, 13'd0, 13'd0, 1'b0},
    '{1'b1, REG_ALLOC_START_RB, 32'd5, 3'd0, 4'd0, 12'd0, 32'h0, 32'h0,
      1'b0, 1'b0, 4'd0, 13'd0, 13'd0, 1'b0},
    '{1'b1, REG_ALLOC_RB_COUNT, 32'd275, 3'd0, 4'd0, 12'd0, 32'h0, 32'h0,
      1'b0, 1'b0, 4'd0, 13'd0, 13'd0, 1'b0},
    '{1'b1, REG_FIRST_SYMBOL, 32'd2, 3'd0, 4'd0, 12'd0, 32'h0, 32'h0,
      1'b0, 1'b0, 4'd0, 13'd0, 13'd0, 1'b0},
    '{1'b1, REG_SYMBOL_COUNT, 32'd12, 3'd0, 4'd0, 12'd0, 32'h0, 32'h0,
      1'b0, 1'b0, 4'd0, 13'd0, 13'd0, 1'b0},
    '{1'b1, REG_DMRS_SYMBOL_MASK, 32'h3FFF, 3'd0, 4'd0, 12'd0, 32'h0, 32'h0,
      1'b0, 1'b0, 4'd0, 13'd0, 13'd0, 1'b0},
    '{1'b1, REG_PORT_COUNT, 32'd8, 3'd0, 4'd0, 12'd0, 32'h0, 32'h0,
      1'b0, 1'b0, 4'd0, 13'd0, 13'd0, 1'b0},
    '{1'b0, REG_UNUSED, 32'd0, 3'd7, 4'd2, 12'd180, 32'hA5A5A5A5, 32'h5A5A5A5A,
      1'b1, 1'b1, 4'd0, 13'd0, 13'd2048, 1'b1},
    '{1'b0, REG_UNUSED, 32'd0, 3'd3, 4'd13, 12'd181, 32'h12345678, 32'h9ABCDEF0,
      1'b1, 1'b1, 4'd11, 13'd4096, 13'd6144, 1'b1},
    '{1'b0, REG_UNUSED, 32'd0, 3'd0, 4'd5, 12'd3479, 32'hDEADBEEF, 32'h0BADF00D,
      1'b0, 1'b0, 4'd0, 13'd0, 13'd0, 1'b0},
    '{1'b0, REG_UNUSED, 32'd0, 3'd0, 4'd2, 12'd179, 32'h11, 32'h22,
      1'b1, 1'b0, 4'd0, 13'd0, 13'd0, 1'b0},
    '{1'b0, REG_UNUSED, 32'd0, 3'd0, 4'd2, 12'd3480, 32'h33, 32'h44,
      1'b1, 1'b0, 4'd0, 13'd0, 13'd0, 1'b0},
    '{1'b0, REG_UNUSED, 32'd0, 3'd0, 4'd1, 12'd200, 32'h55, 32'h66,
      1'b1, 1'b0, 4'd0, 13'd0, 13'd0, 1'b0},
    '{1'b0, REG_UNUSED, 32'd0, 3'd0, 4'd14, 12'd200, 32'h77, 32'h88,
      1'b1, 1'b0, 4'd0, 13'd0, 13'd0, 1'b0},
    // whole carrier, symbols fourteen and fifteen reachable
    '{1'b1, REG_BWP_START_RB, 32'd0, 3'd0, 4'd0, 12'd0, 32'h0, 32'h0,
      1'b0, 1'b0, 4'd0, 13'd0, 13'd0, 1'b0},
    '{1'b1, REG_ALLOC_START_RB, 32'd0, 3'd0, 4'd0, 12'd0, 32'h0, 32'h0,
      1'b0, 1'b0, 4'd0, 13'd0, 13'd0, 1'b0},
    '{1'b1, REG_ALLOC_RB_COUNT, 32'd511, 3'd0, 4'd0, 12'd0, 32'h0, 32'h0,
      1'b0, 1'b0, 4'd0, 13'd0, 13'd0, 1'b0},
    '{1'b1, REG_FIRST_SYMBOL, 32'd13, 3'd0, 4'd0, 12'd0, 32'h0, 32'h0,
      1'b0, 1'b0, 4'd0, 13'd0, 13'd0, 1'b0},
    '{1'b1, REG_SYMBOL_COUNT, 32'd15, 3'd0, 4'd0, 12'd0, 32'h0, 32'h0,
      1'b0, 1'b0, 4'd0, 13'd0, 13'd0, 1'b0},
    '{1'b0, REG_UNUSED, 32'd0, 3'd5, 4'd14, 12'd4095, 32'h80000000, 32'h00000001,
      1'b1, 1'b1, 4'd1, 13'd4095, 13'd8191, 1'b0},
    '{1'b0, REG_UNUSED, 32'd0, 3'd6, 4'd15, 12'd0, 32'h7FFFFFFF, 32'hFFFFFFFE,
      1'b1, 1'b1, 4'd2, 13'd0, 13'd4096, 1'b0},
    '{1'b0, REG_UNUSED, 32'd0, 3'd2, 4'd13, 12'd4094, 32'hC0FFEE00, 32'h00C0FFEE,
      1'b0, 1'b0, 4'd0, 13'd0, 13'd0, 1'b0},
    '{1'b0, REG_UNUSED, 32'd0, 3'd1, 4'd12, 12'd100, 32'h99, 32'hAA,
      1'b1, 1'b0, 4'd0, 13'd0, 13'd0, 1'b0},
    // no ports, then no symbols
    '{1'b1, REG_PORT_COUNT, 32'd0, 3'd0, 4'd0, 12'd0, 32'h0, 32'h0,
      1'b0, 1'b0, 4'd0, 13'd0, 13'd0, 1'b0},
    '{1'b0, REG_UNUSED, 32'd0, 3'd0, 4'd13, 12'd0, 32'hBB, 32'hCC,
      1'b1, 1'b0, 4'd0, 13'd0, 13'd0, 1'b0},
    '{1'b1, REG_PORT_COUNT, 32'd8, 3'd0, 4'd0, 12'd0, 32'h0, 32'h0,
      1'b0, 1'b0, 4'd0, 13'd0, 13'd0, 1'b0},
    '{1'b1, REG_SYMBOL_COUNT, 32'd0, 3'd0, 4'd0, 12'd0, 32'h0, 32'h0,
      1'b0, 1'b0, 4'd0, 13'd0, 13'd0, 1'b0},
    '{1'b0, REG_UNUSED, 32'd0, 3'd0, 4'd13, 12'd0, 32'hDD, 32'hEE,
      1'b1, 1'b0, 4'd0, 13'd0, 13'd0, 1'b0}
  };

  initial begin
    re_elem_t it;
    re_slot_t slot;
    int hits;
    int sc_lo;
    int sc_hi;
    int sym_hi;
    logic [RB_W-1:0] bwp;
    logic [RB_W-1:0] alloc;
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    src_idle_pct = 10;
    snk_idle_pct = 54;
    foreach (dir_tab[i]) begin
      if (dir_tab[i].wr) begin
        settle_idle();
        write_reg(dir_tab[i].idx, dir_tab[i].val);
      end else begin
        it = '{im: dir_tab[i].im, re: dir_tab[i].re, sc: dir_tab[i].sc,
               sym: dir_tab[i].sym, port: dir_tab[i].port};
        slot = '{dmrs: dir_tab[i].dmrs, im: dir_tab[i].im, re: dir_tab[i].re,
                 ia: dir_tab[i].ia, ra: dir_tab[i].ra, sym: dir_tab[i].o_sym,
                 port: dir_tab[i].port};
        send_elem(it, dir_tab[i].typed, dir_tab[i].hit, slot);
      end
    end

    for (int ph = 0; ph < PHASES; ph++) begin
      if (ph < 3) begin
        src_idle_pct = 10;
        snk_idle_pct = 54;
      end else if (ph < 6) begin
        src_idle_pct = 54;
        snk_idle_pct = 10;
      end else begin
        src_idle_pct = 0;
        snk_idle_pct = 0;
      end
      settle_idle();
      case (ph)
        0: begin
          write_reg(REG_BWP_START_RB, 32'd0);
          write_reg(REG_ALLOC_START_RB, 32'd0);
          write_reg(REG_ALLOC_RB_COUNT, 32'd1);
          write_reg(REG_FIRST_SYMBOL, 32'd0);
          write_reg(REG_SYMBOL_COUNT, 32'd1);
          write_reg(REG_DMRS_SYMBOL_MASK, 32'd0);
          write_reg(REG_PORT_COUNT, 32'd1);
        end
        1: begin
          write_reg(REG_BWP_START_RB, 32'd274);
          write_reg(REG_ALLOC_START_RB, 32'd0);
          write_reg(REG_ALLOC_RB_COUNT, 32'd275);
          write_reg(REG_FIRST_SYMBOL, 32'd0);
          write_reg(REG_SYMBOL_COUNT, 32'd14);
          write_reg(REG_DMRS_SYMBOL_MASK, 32'h3FFF);
          write_reg(REG_PORT_COUNT, 32'd8);
        end
        2: begin
          write_reg(REG_BWP_START_RB, 32'd0);
          write_reg(REG_ALLOC_START_RB, 32'd274);
          write_reg(REG_ALLOC_RB_COUNT, 32'd275);
          write_reg(REG_FIRST_SYMBOL, 32'd13);
          write_reg(REG_SYMBOL_COUNT, 32'd14);
          write_reg(REG_DMRS_SYMBOL_MASK, 32'h2AAA);
          write_reg(REG_PORT_COUNT, 32'd8);
        end
        default: begin
          bwp = RB_W'($urandom_range(274, 0));
          alloc = RB_W'($urandom_range((340 - int'(bwp) > 274) ? 274 : 340 - int'(bwp), 0));
          write_reg(REG_BWP_START_RB, 32'(bwp));
          write_reg(REG_ALLOC_START_RB, 32'(alloc));
          write_reg(REG_ALLOC_RB_COUNT, $urandom_range(275, 1));
          write_reg(REG_FIRST_SYMBOL, $urandom_range(13, 0));
          write_reg(REG_SYMBOL_COUNT, $urandom_range(14, 1));
          write_reg(REG_DMRS_SYMBOL_MASK, $urandom_range(16383, 0));
          write_reg(REG_PORT_COUNT, $urandom_range(8, 1));
        end
      endcase
      sc_lo = (int'(c_bwp) + int'(c_alloc)) * SC_PER_RB;
      sc_hi = (int'(c_bwp) + int'(c_alloc) + int'(c_cnt)) * SC_PER_RB - 1;
      if (sc_hi > 4095) sc_hi = 4095;
      sym_hi = int'(c_first) + int'(c_symcnt) - 1;
      if (sym_hi > 15) sym_hi = 15;
      hits = 0;
      while (hits < PHASE_HIT) begin
        it.re = $urandom();
        it.im = $urandom();
        if ($urandom_range(99, 0) < 75) begin
          it.port = PORT_W'($urandom_range(int'(c_ports) - 1, 0));
          it.sym  = SYM_W'($urandom_range(sym_hi, int'(c_first)));
          it.sc   = SC_W'($urandom_range(sc_hi, sc_lo));
        end else begin
          it.port = PORT_W'($urandom());
          it.sym  = SYM_W'($urandom());
          it.sc   = SC_W'($urandom());
        end
        send_elem(it, 1'b0, 1'b0, '0);
        if (demap_slot(it, slot)) begin
          hits++;
          if (ph == 4 && hits == PHASE_HIT / 2) drain_results();
        end
      end
    end

    settle_idle();
    repeat (2) @(negedge clk);
    if (slot_q.size() != 0) begin
      mismatch_cnt++;
      $display("%0t: %0d expected results never arrived", $time, slot_q.size());
    end
    if (mismatch_cnt == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
